// ===== hw/rtl/bounded_undo_redo_history_macros.svh =====
// Assertion macros shared by the undo/redo history RTL.
`ifndef BOUNDED_UNDO_REDO_HISTORY_MACROS_SVH
`define BOUNDED_UNDO_REDO_HISTORY_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define URH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("urh assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define URH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("urh assertion failed");

`endif

// ===== hw/rtl/urh_pkg.sv =====
// Package with the types and constants of the undo/redo history block.
package urh_pkg;

    localparam int SNAP_BITS      = 32;
    localparam int MAX_STEPS_BITS = 7;
    localparam logic [MAX_STEPS_BITS-1:0] MAX_STEPS_RESET = 7'd64;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_UNDO  = 2'd1,
        CMD_REDO  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    // Per-cycle control for one stack of cells.
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } stk_ctrl_t;

endpackage

// ===== hw/rtl/urh_if.sv =====
// Channel interfaces of the undo/redo history block.
interface urh_req_if
    import urh_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [1:0]           cmd;
    logic [SNAP_BITS-1:0] snapshot;

    modport source (output valid, output cmd, output snapshot, input ready);
    modport sink   (input valid, input cmd, input snapshot, output ready);
endinterface

interface urh_rsp_if
    import urh_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [SNAP_BITS-1:0] restored;
    logic                 restored_valid;
    logic                 undo_possible;
    logic                 redo_possible;
    logic                 undo_flag_changed;
    logic                 redo_flag_changed;

    modport source (
        output valid, output restored, output restored_valid,
        output undo_possible, output redo_possible,
        output undo_flag_changed, output redo_flag_changed,
        input  ready
    );
    modport sink (
        input  valid, input restored, input restored_valid,
        input  undo_possible, input redo_possible,
        input  undo_flag_changed, input redo_flag_changed,
        output ready
    );
endinterface

interface urh_cfg_if
    import urh_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [MAX_STEPS_BITS-1:0] max_steps;

    modport source (output valid, output max_steps, input ready);
    modport sink   (input valid, input max_steps, output ready);
endinterface

// ===== hw/rtl/bounded_undo_redo_history.sv =====
// Top level of the bounded undo/redo history of snapshot handles.
//
// Usage: commands arrive as items on req (cmd, snapshot) and each produces
// exactly one result item on rsp. A push stacks the handle on the undo
// stack and empties redo; undo and redo move the current handle onto the
// opposite stack and return the newest entry of their own stack; clear
// empties both. Each result carries the restored handle, whether it is
// valid, whether undo and redo are possible afterwards, and which of those
// two flags changed.
// The cfg channel writes max_steps, the most entries either stack keeps
// (clamped to 1..DEPTH); it is always ready and must only be written while
// the block is idle. A lowered limit takes effect on the next push to a
// stack.
// A command's result is in the output register in the cycle after it is
// accepted. One command is accepted per cycle while the register is free
// or drains: push, pop and trim on the rows of shifting cells never stall.
// If the receiver stalls, the result waits in the output register and req
// drops ready until it is taken. Reset empties both stacks, sets max_steps
// to 64 and marks the output register empty; stack contents are not cleared.
module bounded_undo_redo_history
    import urh_pkg::*;
#(
    parameter int DEPTH       = 64,
    parameter int HANDLE_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    urh_req_if.sink   req,
    urh_rsp_if.source rsp,
    urh_cfg_if.sink   cfg
);

    `include "bounded_undo_redo_history_macros.svh"

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > MAX_STEPS_BITS) ? CNT_W : MAX_STEPS_BITS;

    logic [MAX_STEPS_BITS-1:0] max_steps_reg;

    logic [CMP_W-1:0] steps_ext;
    logic [CMP_W-1:0] lim_cmp;
    logic [CNT_W-1:0] lim;

    logic                   in_fire;
    cmd_t                   cmd;
    logic [HANDLE_BITS-1:0] handle;

    stk_ctrl_t              u_ctrl;
    stk_ctrl_t              r_ctrl;
    logic [HANDLE_BITS-1:0] u_top;
    logic [HANDLE_BITS-1:0] r_top;
    logic [CNT_W-1:0]       u_cnt;
    logic [CNT_W-1:0]       r_cnt;

    logic                   prev_u;
    logic                   prev_r;
    logic                   now_u;
    logic                   now_r;
    logic [HANDLE_BITS-1:0] pick;
    logic                   pick_valid;

    logic                 out_valid_reg;
    logic [SNAP_BITS-1:0] restored_reg;
    logic                 restored_valid_reg;
    logic                 undo_possible_reg;
    logic                 redo_possible_reg;
    logic                 undo_changed_reg;
    logic                 redo_changed_reg;

    // Configuration register; the channel never stalls.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_steps_reg <= MAX_STEPS_RESET;
        end
        else if (cfg.valid)
        begin
            max_steps_reg <= cfg.max_steps;
        end
    end

    // Limit in force is max_steps clamped to the range one to DEPTH.
    assign steps_ext = CMP_W'(max_steps_reg);

    always_comb
    begin
        if (steps_ext == '0)
        begin
            lim_cmp = CMP_W'(1);
        end
        else if (steps_ext > CMP_W'(DEPTH))
        begin
            lim_cmp = CMP_W'(DEPTH);
        end
        else
        begin
            lim_cmp = steps_ext;
        end
    end

    assign lim = lim_cmp[CNT_W-1:0];

    // A new command is taken whenever the output register is free or drains.
    assign req.ready = !out_valid_reg || rsp.ready;
    assign in_fire   = req.valid && req.ready;
    assign cmd       = cmd_t'(req.cmd);
    assign handle    = HANDLE_BITS'(req.snapshot);

    assign prev_u = (u_cnt != '0);
    assign prev_r = (r_cnt != '0);

    // Command decode: drives both stacks and works out the result flags.
    always_comb
    begin
        u_ctrl     = '0;
        r_ctrl     = '0;
        pick       = '0;
        pick_valid = 1'b0;
        now_u      = prev_u;
        now_r      = prev_r;
        unique case (cmd)
            CMD_PUSH:
            begin
                u_ctrl.push  = in_fire;
                r_ctrl.clear = in_fire;
                now_u        = 1'b1;
                now_r        = 1'b0;
            end
            CMD_UNDO:
            begin
                if (prev_u)
                begin
                    r_ctrl.push = in_fire;
                    u_ctrl.pop  = in_fire;
                    pick        = u_top;
                    pick_valid  = 1'b1;
                    now_r       = 1'b1;
                    now_u       = (u_cnt != CNT_W'(1));
                end
            end
            CMD_REDO:
            begin
                if (prev_r)
                begin
                    u_ctrl.push = in_fire;
                    r_ctrl.pop  = in_fire;
                    pick        = r_top;
                    pick_valid  = 1'b1;
                    now_u       = 1'b1;
                    now_r       = (r_cnt != CNT_W'(1));
                end
            end
            CMD_CLEAR:
            begin
                u_ctrl.clear = in_fire;
                r_ctrl.clear = in_fire;
                now_u        = 1'b0;
                now_r        = 1'b0;
            end
            default:
            begin
                now_u = prev_u;
            end
        endcase
    end

    urh_stack #(
        .DEPTH (DEPTH),
        .W     (HANDLE_BITS),
        .CNT_W (CNT_W)
    ) u_undo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (u_ctrl),
        .push_data (handle),
        .lim       (lim),
        .top       (u_top),
        .count     (u_cnt)
    );

    urh_stack #(
        .DEPTH (DEPTH),
        .W     (HANDLE_BITS),
        .CNT_W (CNT_W)
    ) u_redo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (r_ctrl),
        .push_data (handle),
        .lim       (lim),
        .top       (r_top),
        .count     (r_cnt)
    );

    // Output register: holds the result while the receiver stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            restored_reg       <= SNAP_BITS'(pick);
            restored_valid_reg <= pick_valid;
            undo_possible_reg  <= now_u;
            redo_possible_reg  <= now_r;
            undo_changed_reg   <= now_u != prev_u;
            redo_changed_reg   <= now_r != prev_r;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.restored          = restored_reg;
    assign rsp.restored_valid    = restored_valid_reg;
    assign rsp.undo_possible     = undo_possible_reg;
    assign rsp.redo_possible     = redo_possible_reg;
    assign rsp.undo_flag_changed = undo_changed_reg;
    assign rsp.redo_flag_changed = redo_changed_reg;

    // The reported flags must agree with the stack counts they describe.
    `URH_ASSERT_NEXT(a_result_follows, in_fire, out_valid_reg)
    `URH_ASSERT_NEXT(a_undo_flag_count, in_fire, undo_possible_reg == (u_cnt != '0))
    `URH_ASSERT_NEXT(a_redo_flag_count, in_fire, redo_possible_reg == (r_cnt != '0))
    `URH_ASSERT_NEXT(a_clear_empties, in_fire && (cmd == CMD_CLEAR),
                     (u_cnt == '0) && (r_cnt == '0))
    `URH_ASSERT_NOW(a_count_bound, 1'b1,
                    (u_cnt <= CNT_W'(DEPTH)) && (r_cnt <= CNT_W'(DEPTH)))

endmodule

// ===== hw/rtl/urh_cell.sv =====
// One stack entry cell; it loads from its upper neighbor on push, lower on pop.
module urh_cell
    import urh_pkg::*;
#(
    parameter int W = 32
) (
    input  logic      clk,
    input  stk_ctrl_t ctrl,
    input  logic [W-1:0] above,
    input  logic [W-1:0] below,
    output logic [W-1:0] q
);

    logic [W-1:0] entry_reg;
    logic [W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.push)
        begin
            entry_next = above;
        end
        else if (ctrl.pop)
        begin
            entry_next = below;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

// ===== hw/rtl/urh_stack.sv =====
// Bounded stack built as a row of shifting cells, newest entry in cell zero.
module urh_stack
    import urh_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int W     = 32,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  stk_ctrl_t        ctrl,
    input  logic [W-1:0]     push_data,
    input  logic [CNT_W-1:0] lim,
    output logic [W-1:0]     top,
    output logic [CNT_W-1:0] count
);

    logic [W-1:0]     q [DEPTH];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W:0]   cnt_inc;

    // Cell i takes cell i-1 on push and cell i+1 on pop; entries past the
    // count are stale and never read.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [W-1:0] above;
        logic [W-1:0] below;

        if (i == 0)
        begin : g_first
            assign above = push_data;
        end
        else
        begin : g_mid
            assign above = q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign below = q[i];
        end
        else
        begin : g_inner
            assign below = q[i+1];
        end

        urh_cell #(.W(W)) u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .above (above),
            .below (below),
            .q     (q[i])
        );
    end

    assign cnt_inc = {1'b0, cnt_reg} + {{CNT_W{1'b0}}, 1'b1};

    // A push past the limit drops the oldest entries by capping the count.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctrl.clear)
        begin
            cnt_next = '0;
        end
        else if (ctrl.push)
        begin
            if (cnt_inc > {1'b0, lim})
            begin
                cnt_next = lim;
            end
            else
            begin
                cnt_next = cnt_inc[CNT_W-1:0];
            end
        end
        else if (ctrl.pop)
        begin
            cnt_next = cnt_reg - {{(CNT_W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign top   = q[0];
    assign count = cnt_reg;

endmodule

// ===== bench/bounded_undo_redo_history_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the bounded undo/redo history block.
module bounded_undo_redo_history_tb;
    import urh_pkg::*;

    // The block is built at its default size; the shadow history below keeps
    // the same depth so that trims and ring wrap-around line up.
    localparam int STACK_DEPTH = 64;
    localparam int HANDLE_WIDTH = 32;
    localparam int UNDO_SIDE = 0;
    localparam int REDO_SIDE = 1;
    localparam logic [MAX_STEPS_BITS-1:0] RESET_MAX_STEPS = 7'd64;
    localparam logic [SNAP_BITS-1:0] ALL_ONES = '1;

    // The block answers in the cycle after it takes an item, so a handful of
    // cycles is enough to see any stray result at the end of the run.
    localparam int SETTLE_CYCLES = 4;

    // Cycles without any handshake before the run is declared hung. A correct
    // run never comes near it, even with the receiver stalling half the time.
    localparam int WATCHDOG_LIMIT = 2000;

    // One result item as the block should report it.
    typedef struct packed {
        logic [SNAP_BITS-1:0] restored;
        logic                 restored_valid;
        logic                 undo_possible;
        logic                 redo_possible;
        logic                 undo_changed;
        logic                 redo_changed;
    } step_result_t;

    logic clk;
    logic rst_n;

    urh_req_if req_ch ();
    urh_rsp_if rsp_ch ();
    urh_cfg_if cfg_ch ();

    // Shadow copy of both history stacks: ring storage, oldest slot and fill.
    logic [SNAP_BITS-1:0]      history_ring [2][STACK_DEPTH];
    int                        ring_base [2];
    int                        ring_fill [2];
    logic [MAX_STEPS_BITS-1:0] max_steps_shadow;

    // Results still owed by the block, oldest first.
    step_result_t pending_results [$];

    int error_count;
    int quiet_cycles;
    int sender_idle_pct;
    int receiver_stall_pct;

    bounded_undo_redo_history #(
        .DEPTH       (STACK_DEPTH),
        .HANDLE_BITS (HANDLE_WIDTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Shadow history
    // ------------------------------------------------------------------

    // The register is clamped to 1..STACK_DEPTH: zero keeps one entry and
    // anything above the depth keeps the full depth.
    function automatic int active_limit();
        int lim;
        lim = int'(max_steps_shadow);
        if (lim < 1)
        begin
            lim = 1;
        end
        if (lim > STACK_DEPTH)
        begin
            lim = STACK_DEPTH;
        end
        return lim;
    endfunction

    // Stacks a handle and then drops as many of the oldest entries as the
    // limit demands. A lowered limit therefore bites here all at once.
    function automatic void stack_handle(int side, logic [SNAP_BITS-1:0] handle);
        int lim;
        int fill;
        lim = active_limit();
        history_ring[side][(ring_base[side] + ring_fill[side]) % STACK_DEPTH] = handle;
        fill = ring_fill[side] + 1;
        if (fill > lim)
        begin
            ring_base[side] = (ring_base[side] + fill - lim) % STACK_DEPTH;
            fill = lim;
        end
        ring_fill[side] = fill;
    endfunction

    // Only ever called on a stack that holds at least one entry, so no
    // slot that was never written is read.
    function automatic logic [SNAP_BITS-1:0] unstack_handle(int side);
        ring_fill[side] = ring_fill[side] - 1;
        return history_ring[side][(ring_base[side] + ring_fill[side]) % STACK_DEPTH];
    endfunction

    function automatic void empty_stack(int side);
        ring_base[side] = 0;
        ring_fill[side] = 0;
    endfunction

    // Applies one command to the shadow history and returns what the block
    // must report for it.
    function automatic step_result_t predict_step(cmd_t op, logic [SNAP_BITS-1:0] handle);
        step_result_t outcome;
        logic         undo_before;
        logic         redo_before;
        undo_before = (ring_fill[UNDO_SIDE] != 0);
        redo_before = (ring_fill[REDO_SIDE] != 0);
        outcome = '0;
        case (op)
            CMD_PUSH:
            begin
                // A fresh state makes every redo step meaningless.
                stack_handle(UNDO_SIDE, handle);
                empty_stack(REDO_SIDE);
            end
            CMD_UNDO:
            begin
                // With nothing to undo the step changes nothing at all.
                if (ring_fill[UNDO_SIDE] != 0)
                begin
                    stack_handle(REDO_SIDE, handle);
                    outcome.restored = unstack_handle(UNDO_SIDE);
                    outcome.restored_valid = 1'b1;
                end
            end
            CMD_REDO:
            begin
                if (ring_fill[REDO_SIDE] != 0)
                begin
                    stack_handle(UNDO_SIDE, handle);
                    outcome.restored = unstack_handle(REDO_SIDE);
                    outcome.restored_valid = 1'b1;
                end
            end
            default:
            begin
                empty_stack(UNDO_SIDE);
                empty_stack(REDO_SIDE);
            end
        endcase
        outcome.undo_possible = (ring_fill[UNDO_SIDE] != 0);
        outcome.redo_possible = (ring_fill[REDO_SIDE] != 0);
        outcome.undo_changed = (outcome.undo_possible != undo_before);
        outcome.redo_changed = (outcome.redo_possible != redo_before);
        return outcome;
    endfunction

    // Appends one expectation behind those already pending.
    function automatic void append_expected(step_result_t expected);
        pending_results = {pending_results, expected};
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_field(string name, logic [SNAP_BITS-1:0] want,
                               logic [SNAP_BITS-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Every result item taken at a clock edge is compared with the oldest
    // pending expectation. The receiver's ready for the next edge is then
    // drawn from the current stall rate.
    always @(posedge clk)
    begin : result_checker
        step_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result item with nothing pending, expected none, actual %h",
                         $time, rsp_ch.restored);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("restored", want.restored, rsp_ch.restored);
                check_field("restored_valid", SNAP_BITS'(want.restored_valid),
                            SNAP_BITS'(rsp_ch.restored_valid));
                check_field("undo_possible", SNAP_BITS'(want.undo_possible),
                            SNAP_BITS'(rsp_ch.undo_possible));
                check_field("redo_possible", SNAP_BITS'(want.redo_possible),
                            SNAP_BITS'(rsp_ch.redo_possible));
                check_field("undo_flag_changed", SNAP_BITS'(want.undo_changed),
                            SNAP_BITS'(rsp_ch.undo_flag_changed));
                check_field("redo_flag_changed", SNAP_BITS'(want.redo_changed),
                            SNAP_BITS'(rsp_ch.redo_flag_changed));
            end
        end
        rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // The watchdog restarts on any handshake; a long quiet stretch means the
    // block has stopped taking or giving items.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Sends one command item. Before it the sender may sit idle for a few
    // cycles; valid is only ever assigned once per clock edge, so a valid
    // that stays high across back-to-back items is never dropped and raised
    // in the same step. The expectation is formed at the accepting edge.
    task automatic send_command(cmd_t op, logic [SNAP_BITS-1:0] handle);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd <= op;
        req_ch.snapshot <= handle;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        append_expected(predict_step(op, handle));
    endtask

    // Lowers valid after the last item of a burst and lets that edge pass.
    task automatic end_burst();
        req_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // The sender stops and holds off until the block has answered every item.
    task automatic pause_until_drained();
        end_burst();
        wait_drained();
    endtask

    // The limit is only changed while the block is idle: every item sent so
    // far has been answered, and each item always yields a result.
    task automatic write_max_steps(logic [MAX_STEPS_BITS-1:0] value);
        pause_until_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.max_steps <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        max_steps_shadow = value;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_idling(int idle_pct, int stall_pct);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty-stack corner cases, handle extremes and every command, run at
    // the reset limit with no idling on either side.
    task automatic test_directed_cases();
        set_idling(0, 0);
        send_command(CMD_UNDO, '0);            // undo with nothing to undo
        send_command(CMD_REDO, ALL_ONES);      // redo with nothing to redo
        send_command(CMD_CLEAR, ALL_ONES);     // clear with both stacks empty
        send_command(CMD_PUSH, '0);
        send_command(CMD_PUSH, ALL_ONES);
        send_command(CMD_PUSH, 32'h5a5a_a5a5);
        send_command(CMD_UNDO, 32'h1234_5678);
        send_command(CMD_UNDO, ALL_ONES);
        send_command(CMD_REDO, '0);
        send_command(CMD_REDO, 32'h8000_0001);
        send_command(CMD_REDO, 32'h7fff_fffe); // redo stack already used up
        send_command(CMD_UNDO, 32'h0000_ffff);
        send_command(CMD_UNDO, 32'hffff_0000);
        send_command(CMD_UNDO, 32'h0f0f_0f0f);
        send_command(CMD_UNDO, 32'hf0f0_f0f0); // undo past the oldest entry
        send_command(CMD_CLEAR, '0);           // clear with only redo filled
        send_command(CMD_PUSH, 32'hdead_0001);
        send_command(CMD_PUSH, 32'hdead_0002);
        send_command(CMD_UNDO, 32'hdead_0003);
        send_command(CMD_CLEAR, 32'hdead_0004); // both flags drop together
        send_command(CMD_PUSH, 32'ha5a5_5a5a);
    endtask

    // Fills undo past full depth and redo to it with the register above its
    // range, then lowers the limit so stacking onto undo trims many entries.
    task automatic test_deep_history();
        int k;
        write_max_steps(7'd127);
        set_idling(0, 0);
        for (k = 0; k < STACK_DEPTH + 4; k++)
        begin
            send_command(CMD_PUSH, $urandom());
        end
        for (k = 0; k < STACK_DEPTH + 2; k++)
        begin
            send_command(CMD_UNDO, $urandom());
        end
        for (k = 0; k < STACK_DEPTH + 2; k++)
        begin
            send_command(CMD_REDO, $urandom());
        end
        write_max_steps(7'd5);
        set_idling(19, 19);
        send_command(CMD_UNDO, $urandom());
        send_command(CMD_REDO, $urandom());
        for (k = 0; k < 8; k++)
        begin
            send_command(CMD_UNDO, $urandom());
        end
    endtask

    // Random commands in bursts with a purpose: building history, rewinding
    // it, wandering back and forth, or plain noise that may clear it all.
    // Halfway through, the sender holds off until every result is back.
    task automatic run_random_phase(int items);
        int   sent;
        int   burst;
        int   kind;
        int   roll;
        int   k;
        cmd_t op;
        sent = 0;
        while (sent < items)
        begin
            kind = $urandom_range(99);
            burst = $urandom_range(40, 4);
            for (k = 0; k < burst && sent < items; k++)
            begin
                roll = $urandom_range(99);
                if (kind < 40)
                begin
                    op = (roll < 85) ? CMD_PUSH : ((roll < 93) ? CMD_UNDO : CMD_REDO);
                end
                else if (kind < 65)
                begin
                    op = (roll < 80) ? CMD_UNDO : CMD_PUSH;
                end
                else if (kind < 90)
                begin
                    op = (roll < 50) ? CMD_UNDO : CMD_REDO;
                end
                else
                begin
                    op = cmd_t'($urandom_range(3));
                end
                send_command(op, $urandom());
                sent++;
                if (sent == items / 2)
                begin
                    pause_until_drained();
                end
            end
        end
    endtask

    // Several limits, the extremes among them, each under an idling
    // pattern. Stacks are not cleared between phases, so a new lower limit
    // meets stacks filled under the old one.
    task automatic test_random_phases();
        write_max_steps(7'd1);
        set_idling(0, 0);
        run_random_phase(80);

        write_max_steps(7'd0);
        set_idling(46, 0);
        run_random_phase(70);

        write_max_steps(7'd2);
        set_idling(0, 46);
        run_random_phase(80);

        write_max_steps(7'd127);
        set_idling(19, 19);
        run_random_phase(100);

        write_max_steps(7'($urandom_range(63, 3)));
        set_idling(46, 0);
        run_random_phase(90);

        write_max_steps(7'd64);
        set_idling(0, 46);
        run_random_phase(90);
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_PUSH;
        req_ch.snapshot = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.max_steps = RESET_MAX_STEPS;
        error_count = 0;
        quiet_cycles = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;

        // Reset leaves both stacks empty and the limit at its full depth.
        empty_stack(UNDO_SIDE);
        empty_stack(REDO_SIDE);
        max_steps_shadow = RESET_MAX_STEPS;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_deep_history();
        test_random_phases();

        // Wait for the last answers, then a few more cycles so that any
        // result the block sends without cause is caught by the checker.
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
